// File: hw/rtl/rvalu_pkg.sv
// Shared types, constants and helpers for the RV32I ALU execute block.
// No dependencies; imported by every module of the block.
`default_nettype none

package rvalu_pkg;

  localparam int Xlen     = 32;
  localparam int RegAddrW = 5;                 // rd/rs1/rs2 field width in the instruction
  localparam int NumRegs  = 32;                // legal range 16..32
  localparam int RegIdxW  = $clog2(NumRegs);

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_XOR  = 4'd2,
    OP_OR   = 4'd3,
    OP_AND  = 4'd4,
    OP_SLL  = 4'd5,
    OP_SRL  = 4'd6,
    OP_SRA  = 4'd7,
    OP_SLT  = 4'd8,
    OP_SLTU = 4'd9,
    OP_ADDI = 4'd10,
    OP_XORI = 4'd11,
    OP_ORI  = 4'd12,
    OP_ANDI = 4'd13,
    OP_SLLI = 4'd14,
    OP_SRLI = 4'd15
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [Xlen-1:0]  instr_word;
  } in_beat_t;

  typedef struct packed {
    logic [RegAddrW-1:0] dest_index;
    logic [Xlen-1:0]     dest_value;
  } out_beat_t;

  typedef struct packed {
    logic                en;
    logic [RegAddrW-1:0] addr;
    logic [Xlen-1:0]     data;
  } rf_wr_t;

  // True for an index that maps onto a real, writable register (not x0).
  function automatic logic reg_present(logic [RegAddrW-1:0] idx);
    return (idx != '0) && (int'(idx) < NumRegs);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rvalu_regfile.sv
// Integer register file: one write port, two registered read ports with write-through.
// Depends on rvalu_pkg. Per-entry valid bits make unwritten entries read as zero.
`default_nettype none

module rvalu_regfile
  import rvalu_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rd_en_i,
  input  wire logic [RegAddrW-1:0] rs1_addr_i,
  input  wire logic [RegAddrW-1:0] rs2_addr_i,
  input  wire rf_wr_t              wr_i,
  output logic      [Xlen-1:0]     rs1_data_o,
  output logic      [Xlen-1:0]     rs2_data_o
);

  logic [Xlen-1:0]    mem [NumRegs];
  logic [NumRegs-1:0] valid_q;
  logic [Xlen-1:0]    rs1_data_q;
  logic [Xlen-1:0]    rs2_data_q;

  // wr_i.en is only raised for present, nonzero indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr[RegIdxW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[RegIdxW-1:0]] <= wr_i.data;
    end
    if (rd_en_i) begin
      // same-edge write goes straight through to the reader
      if (wr_i.en && (wr_i.addr == rs1_addr_i)) begin
        rs1_data_q <= wr_i.data;
      end else if (reg_present(rs1_addr_i) && valid_q[rs1_addr_i[RegIdxW-1:0]]) begin
        rs1_data_q <= mem[rs1_addr_i[RegIdxW-1:0]];
      end else begin
        rs1_data_q <= '0;
      end
      if (wr_i.en && (wr_i.addr == rs2_addr_i)) begin
        rs2_data_q <= wr_i.data;
      end else if (reg_present(rs2_addr_i) && valid_q[rs2_addr_i[RegIdxW-1:0]]) begin
        rs2_data_q <= mem[rs2_addr_i[RegIdxW-1:0]];
      end else begin
        rs2_data_q <= '0;
      end
    end
  end

  assign rs1_data_o = rs1_data_q;
  assign rs2_data_o = rs2_data_q;

endmodule

`default_nettype wire

// File: hw/rtl/rvalu_alu.sv
// Combinational RV32I integer ALU: register and immediate forms.
// Depends on rvalu_pkg for the op encoding.
`default_nettype none

module rvalu_alu
  import rvalu_pkg::*;
(
  input  wire alu_op_e         op_i,
  input  wire logic [Xlen-1:0] rs1_val_i,
  input  wire logic [Xlen-1:0] rs2_val_i,
  input  wire logic [Xlen-1:0] imm_i,
  output logic      [Xlen-1:0] result_o
);

  logic [4:0] shamt_r;
  logic [4:0] shamt_i;

  assign shamt_r = rs2_val_i[4:0];
  assign shamt_i = imm_i[4:0];

  always_comb begin
    unique case (op_i)
      OP_ADD:  result_o = rs1_val_i + rs2_val_i;
      OP_SUB:  result_o = rs1_val_i - rs2_val_i;
      OP_XOR:  result_o = rs1_val_i ^ rs2_val_i;
      OP_OR:   result_o = rs1_val_i | rs2_val_i;
      OP_AND:  result_o = rs1_val_i & rs2_val_i;
      OP_SLL:  result_o = rs1_val_i << shamt_r;
      OP_SRL:  result_o = rs1_val_i >> shamt_r;
      OP_SRA:  result_o = $unsigned($signed(rs1_val_i) >>> shamt_r);
      OP_SLT:  result_o = {{(Xlen-1){1'b0}}, $signed(rs1_val_i) < $signed(rs2_val_i)};
      OP_SLTU: result_o = {{(Xlen-1){1'b0}}, rs1_val_i < rs2_val_i};
      OP_ADDI: result_o = rs1_val_i + imm_i;
      OP_XORI: result_o = rs1_val_i ^ imm_i;
      OP_ORI:  result_o = rs1_val_i | imm_i;
      OP_ANDI: result_o = rs1_val_i & imm_i;
      OP_SLLI: result_o = rs1_val_i << shamt_i;
      OP_SRLI: result_o = rs1_val_i >> shamt_i;
      default: result_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/rv32i_alu_execute_top.sv
// RV32I ALU execute block. An accepted input beat passes through a register-file read
// stage, then an ALU stage into the output register, and then leaves as a result beat.
// Throughput: one beat per cycle while out_stall_i is low; back-to-back dependencies resolve
// by write-through in the register file's registered read port.
// Reset: control state cleared; all registers read zero until written (per-entry valid
// bits, no clearing pass). Depends on rvalu_pkg, rvalu_regfile, rvalu_alu.
`default_nettype none

module rv32i_alu_execute_top
  import rvalu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_beat_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_beat_o
);

  logic      ex_valid_q, ex_valid_d;
  in_beat_t  ex_beat_q;
  logic      out_valid_q, out_valid_d;
  out_beat_t out_beat_q;

  logic      in_accept;
  logic      out_free;
  logic      ex_adv;

  logic [RegAddrW-1:0] ex_rd;
  logic [Xlen-1:0]     ex_imm;
  logic [Xlen-1:0]     rs1_val, rs2_val;
  logic [Xlen-1:0]     alu_res;
  logic [Xlen-1:0]     dest_val;
  rf_wr_t              rf_wr;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign ex_adv     = ex_valid_q && out_free;
  assign in_stall_o = ex_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign ex_valid_d  = in_accept || (ex_valid_q && !out_free);
  assign out_valid_d = ex_adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ex_valid_q  <= ex_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ex_beat_q <= in_beat_i;
    end
    if (ex_adv) begin
      out_beat_q.dest_index <= ex_rd;
      out_beat_q.dest_value <= dest_val;
    end
  end

  rvalu_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rs1_addr_i (in_beat_i.instr_word[19:15]),
    .rs2_addr_i (in_beat_i.instr_word[24:20]),
    .wr_i       (rf_wr),
    .rs1_data_o (rs1_val),
    .rs2_data_o (rs2_val)
  );

  assign ex_rd  = ex_beat_q.instr_word[11:7];
  assign ex_imm = {{(Xlen-12){ex_beat_q.instr_word[31]}}, ex_beat_q.instr_word[31:20]};

  rvalu_alu u_alu (
    .op_i      (ex_beat_q.op),
    .rs1_val_i (rs1_val),
    .rs2_val_i (rs2_val),
    .imm_i     (ex_imm),
    .result_o  (alu_res)
  );

  // x0 reports zero; out-of-range rd still reports the computed value
  assign dest_val = (ex_rd == '0) ? '0 : alu_res;

  assign rf_wr.en   = ex_adv && reg_present(ex_rd);
  assign rf_wr.addr = ex_rd;
  assign rf_wr.data = alu_res;

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

`default_nettype wire
